[src/jsu_pkg.sv]
package jsu_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;
    localparam int MAX_OUT  = 4;
    localparam int CP_W     = 21;

    // status codes
    localparam logic [STATUS_W-1:0] ST_RUNNING     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_QUOTE    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_END_BSLASH  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ESC     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_MISSING_LOW = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_LOW     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_CONTROL     = 4'd8;
    localparam logic [STATUS_W-1:0] ST_UNTERM      = 4'd9;

    localparam logic [CP_W-1:0] CP_PLANE1 = 21'h10000;

    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [2:0]                     nbytes;
    } utf8_t;

    // one decoded input byte worth of results
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [2:0]                     nbytes;
        logic [STATUS_W-1:0]            status;
    } grp_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
        utf8_t e;
        e.bytes = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.nbytes   = 3'd1;
        end
        else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.nbytes   = 3'd2;
        end
        else if (cp < CP_PLANE1) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.nbytes   = 3'd3;
        end
        else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.nbytes   = 3'd4;
        end
        return e;
    endfunction

endpackage

[src/jsu_in_if.sv]
interface jsu_in_if
    import jsu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              text_ends;

    modport source (output valid, output in_byte, output text_ends, input ready);
    modport sink   (input valid, input in_byte, input text_ends, output ready);
endinterface

[src/jsu_out_if.sv]
interface jsu_out_if
    import jsu_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                has_byte;
    logic [STATUS_W-1:0] status;
    logic                last_of_run;

    modport source (output valid, output out_byte, output has_byte, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input status,
                    input last_of_run, output ready);
endinterface

[src/jsu_decode.sv]
module jsu_decode
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              text_ends,
    output grp_t              grp
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_STR     = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX1    = 3'd3;
    localparam logic [2:0] PH_WANT_BS = 3'd4;
    localparam logic [2:0] PH_WANT_U  = 3'd5;
    localparam logic [2:0] PH_HEX2    = 3'd6;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_U      = 8'h75;

    logic [2:0]  phase_reg, phase_next, phase_eff;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  hs_reg, hs_next;

    logic [4:0]      hv;
    logic [15:0]     acc_sh;
    logic [CP_W-1:0] cp_pair, cp_sel;
    utf8_t           enc;
    logic [8:0]      esc_map;
    logic [STATUS_W-1:0] st;

    always_comb
    begin
        phase_eff = (phase_reg > PH_HEX2) ? PH_IDLE : phase_reg;
        hv        = hex_value(in_byte);
        acc_sh    = {acc_reg[11:0], hv[3:0]};
        cp_pair   = CP_PLANE1 + {1'b0, hs_reg, acc_sh[9:0]};
        cp_sel    = (phase_eff == PH_HEX2) ? cp_pair : {5'd0, acc_sh};
        enc       = utf8_encode(cp_sel);

        // bit 8 set: not a simple escape
        case (in_byte)
            CH_QUOTE:  esc_map = 9'h022;
            CH_BSLASH: esc_map = 9'h05C;
            CH_SLASH:  esc_map = 9'h02F;
            8'h62:     esc_map = 9'h008;
            8'h66:     esc_map = 9'h00C;
            8'h6E:     esc_map = 9'h00A;
            8'h72:     esc_map = 9'h00D;
            8'h74:     esc_map = 9'h009;
            default:   esc_map = 9'h100;
        endcase
    end

    always_comb
    begin
        phase_next = phase_eff;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        hs_next    = hs_reg;
        st         = ST_RUNNING;
        grp.bytes  = '0;
        grp.nbytes = 3'd0;

        case (phase_eff)
            PH_STR:
            begin
                if (in_byte == CH_QUOTE)
                    st = ST_COMPLETE;
                else if (in_byte == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                    if (text_ends) st = ST_END_BSLASH;
                end
                else if (in_byte < 8'h20)
                    st = ST_CONTROL;
                else
                begin
                    grp.bytes[0] = in_byte;
                    grp.nbytes   = 3'd1;
                    if (text_ends) st = ST_UNTERM;
                end
            end
            PH_ESC:
            begin
                if (!esc_map[8])
                begin
                    grp.bytes[0] = esc_map[7:0];
                    grp.nbytes   = 3'd1;
                    phase_next   = PH_STR;
                    if (text_ends) st = ST_UNTERM;
                end
                else if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX1;
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                    if (text_ends) st = ST_BAD_HEX;
                end
                else
                    st = ST_BAD_ESC;
            end
            PH_HEX1:
            begin
                if (!hv[4])
                    st = ST_BAD_HEX;
                else
                begin
                    acc_next = acc_sh;
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next = 2'd0;
                        if (acc_sh[15:10] == 6'b110110)
                        begin
                            hs_next    = acc_sh[9:0];
                            phase_next = PH_WANT_BS;
                            if (text_ends) st = ST_MISSING_LOW;
                        end
                        else
                        begin
                            grp.bytes  = enc.bytes;
                            grp.nbytes = enc.nbytes;
                            phase_next = PH_STR;
                            if (text_ends) st = ST_UNTERM;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        if (text_ends) st = ST_BAD_HEX;
                    end
                end
            end
            PH_WANT_BS:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    phase_next = PH_WANT_U;
                    if (text_ends) st = ST_MISSING_LOW;
                end
                else
                    st = ST_MISSING_LOW;
            end
            PH_WANT_U:
            begin
                if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX2;
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                    if (text_ends) st = ST_BAD_LOW;
                end
                else
                    st = ST_MISSING_LOW;
            end
            PH_HEX2:
            begin
                if (!hv[4])
                    st = ST_BAD_LOW;
                else
                begin
                    acc_next = acc_sh;
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next = 2'd0;
                        if (acc_sh[15:10] != 6'b110111)
                            st = ST_BAD_LOW;
                        else
                        begin
                            grp.bytes  = enc.bytes;
                            grp.nbytes = enc.nbytes;
                            phase_next = PH_STR;
                            if (text_ends) st = ST_UNTERM;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        if (text_ends) st = ST_BAD_LOW;
                    end
                end
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    phase_next = PH_STR;
                    if (text_ends) st = ST_UNTERM;
                end
                else
                    st = ST_NO_QUOTE;
            end
        endcase

        // any final status drops back to idle
        if (st != ST_RUNNING)
        begin
            phase_next = PH_IDLE;
            acc_next   = 16'd0;
            cnt_next   = 2'd0;
            hs_next    = 10'd0;
        end
        grp.status = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            hs_reg    <= 10'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            hs_reg    <= hs_next;
        end
    end

endmodule

[src/jsu_serialize.sv]
module jsu_serialize
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  grp_t       grp,
    output logic       can_load,
    jsu_out_if.source  result
);

    grp_t       grp_reg;
    logic       full_reg;
    logic [1:0] idx_reg;
    logic [1:0] last_idx;
    logic       is_last;
    logic       has;

    always_comb
    begin
        has      = (grp_reg.nbytes != 3'd0);
        last_idx = has ? 2'(grp_reg.nbytes - 3'd1) : 2'd0;
        is_last  = (idx_reg == last_idx);
        can_load = !full_reg || (is_last && result.ready);

        result.valid       = full_reg;
        result.has_byte    = has;
        result.out_byte    = has ? grp_reg.bytes[idx_reg] : '0;
        result.status      = is_last ? grp_reg.status : ST_RUNNING;
        result.last_of_run = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (full_reg && result.ready)
        begin
            if (is_last)
                full_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp;
    end

endmodule

[src/json_string_unescaper_utf8_top.sv]
// JSON string unescaper: feed the raw text of one string literal, opening quote
// first, one byte per input beat; decoded UTF-8 leaves one byte per output beat,
// and the final beat for each input byte has last_of_run set and carries the
// status (nonzero means the string ended, and on an error code the bytes already
// emitted should be dropped). Input is taken every cycle while each byte yields
// at most one output beat and the output is ready; a byte that completes a \u
// escape yielding more than one UTF-8 byte stalls the input until the last of
// them is taken by the single-byte output channel. Results are registered and
// appear in the cycle after the input beat. Any nonzero status returns the
// block to idle, waiting for the next opening quote.
module json_string_unescaper_utf8_top
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source result
);

    grp_t grp;
    logic can_load;
    logic accept;

    assign text.ready = can_load;
    assign accept     = text.valid && can_load;

    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (text.in_byte),
        .text_ends (text.text_ends),
        .grp       (grp)
    );

    jsu_serialize u_serialize (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .grp      (grp),
        .can_load (can_load),
        .result   (result)
    );

endmodule
